### hdl/tsode_pkg.sv
// Shared widths, register indexes, reset values and saturation helper for the ODE step block.
`timescale 1ns / 1ps

package tsode_pkg;

  // Default number of fraction bits of a population word
  localparam int FRAC_BITS  = 24;
  // Fraction bits of coefficients and step size
  localparam int COEF_BITS  = 12;
  localparam int POP_W      = 32;
  localparam int COEF_W     = 16;
  localparam int STEP_W     = 16;
  localparam int ROW_W      = 3 * COEF_W;
  localparam int NSPEC      = 3;
  // Working width for values that are clamped back to a population word
  localparam int SATW       = 72;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  localparam logic [CFG_IDX_W-1:0] REG_METHOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd4;

  // Integration methods
  localparam logic METHOD_EULER = 1'b0;
  localparam logic METHOD_HEUN  = 1'b1;

  // Reset values: Heun, h about 0.01, default interaction matrix
  localparam logic              RST_METHOD = METHOD_HEUN;
  localparam logic [STEP_W-1:0] RST_STEP   = 16'd41;
  localparam logic [ROW_W-1:0]  RST_ROW0   = 48'd8796227241984;
  localparam logic [ROW_W-1:0]  RST_ROW1   = 48'd1765204752384;
  localparam logic [ROW_W-1:0]  RST_ROW2   = 48'd1760963461120;

  typedef logic signed [POP_W-1:0] pop_t;
  typedef logic [ROW_W-1:0]        row_t;

  typedef struct packed {
    logic clip;
    pop_t val;
  } sat_t;

  localparam logic signed [SATW-1:0] SAT_MAX = SATW'(32'sh7FFF_FFFF);
  localparam logic signed [SATW-1:0] SAT_MIN = SATW'(32'sh8000_0000);

  // Clamp a wide signed value to the 32-bit signed range, flag when clamped
  function automatic sat_t sat32(input logic signed [SATW-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r.clip = 1'b1;
      r.val  = 32'sh8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[POP_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/tsode_deriv.sv
// Four-stage pipelined derivative unit: d_i = x_i * sum_j A_ij * (1 - x_j).
`timescale 1ns / 1ps

module tsode_deriv #(
  parameter int FRAC_BITS = tsode_pkg::FRAC_BITS
) (
  input  logic             clk,
  input  logic [3:0]       ld,
  input  tsode_pkg::pop_t  x [tsode_pkg::NSPEC],
  input  tsode_pkg::row_t  rows [tsode_pkg::NSPEC],
  output tsode_pkg::pop_t  d [tsode_pkg::NSPEC],
  output logic             clip
);

  localparam int NS   = tsode_pkg::NSPEC;
  localparam int CW   = tsode_pkg::COEF_W;
  localparam int CB   = tsode_pkg::COEF_BITS;
  localparam int PWD  = tsode_pkg::POP_W;
  localparam int SATW = tsode_pkg::SATW;
  // 1 - x needs room for 2^FRAC_BITS plus the full population range
  localparam int SW   = ((FRAC_BITS > PWD - 1) ? FRAC_BITS : PWD - 1) + 2;
  localparam int PW   = CW + SW;
  localparam int SUMW = PW + 2;
  localparam int MW   = 2 * PWD + 1;

  localparam logic signed [SW-1:0]   ONE   = SW'(1) <<< FRAC_BITS;
  localparam logic signed [SUMW-1:0] RND_C = SUMW'(1) <<< (CB - 1);
  localparam logic signed [MW-1:0]   RND_F = MW'(1) <<< (FRAC_BITS - 1);

  logic signed [SW-1:0]     s    [NS];
  logic signed [CW-1:0]     a    [NS][NS];
  logic signed [PW-1:0]     p1   [NS][NS];
  tsode_pkg::pop_t          x1   [NS];
  logic signed [SUMW-1:0]   sum  [NS];
  tsode_pkg::sat_t          sc   [NS];
  tsode_pkg::pop_t          acc2 [NS];
  tsode_pkg::pop_t          x2   [NS];
  logic                     clip2;
  logic signed [2*PWD-1:0]  m3   [NS];
  logic                     clip3;
  tsode_pkg::sat_t          dc   [NS];

  // stage 1: one minus x, coefficient products
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      s[j] = ONE - SW'(x[j]);
    end
    for (int i = 0; i < NS; i++) begin
      for (int j = 0; j < NS; j++) begin
        a[i][j] = rows[i][CW*j +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < NS; i++) begin
        x1[i] <= x[i];
        for (int j = 0; j < NS; j++) begin
          p1[i][j] <= PW'(a[i][j]) * PW'(s[j]);
        end
      end
    end
  end

  // stage 2: row sum, round off coefficient fraction, clamp
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      sum[i] = SUMW'(p1[i][0]) + SUMW'(p1[i][1]) + SUMW'(p1[i][2]);
      sc[i]  = tsode_pkg::sat32(SATW'((sum[i] + RND_C) >>> CB));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < NS; i++) begin
        acc2[i] <= sc[i].val;
        x2[i]   <= x1[i];
      end
      clip2 <= sc[0].clip | sc[1].clip | sc[2].clip;
    end
  end

  // stage 3: population times weighted sum
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < NS; i++) begin
        m3[i] <= x2[i] * acc2[i];
      end
      clip3 <= clip2;
    end
  end

  // stage 4: round off population fraction, clamp
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      dc[i] = tsode_pkg::sat32(SATW'((MW'(m3[i]) + RND_F) >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int i = 0; i < NS; i++) begin
        d[i] <= dc[i].val;
      end
      clip <= clip3 | dc[0].clip | dc[1].clip | dc[2].clip;
    end
  end

endmodule

### hdl/three_species_ode_step_top.sv
// Top level: one Euler or Heun time step of a three-species population model.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word of three populations,
//   signed fixed point with FRAC_BITS fraction bits. Output channel
//   (out_valid/out_ready) returns the populations one time step later plus a
//   saturated flag that is set when any intermediate or final value clamped.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   method (0), step_size (1) and the three coefficient rows (2..4); other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// Path: an accepted word passes 13 register stages in order: input, 4-stage
//   derivative, Euler product and update, 4-stage derivative, Heun product,
//   output. Both methods take the same path and latency.
// Throughput: one word per cycle unless the output stalls; every stage holds one word.
// Stall: when out_ready is low the stages fill up one by one, bubbles are
//   squeezed out, and in_ready drops only once all 13 stages hold a word.
// Reset: all stage valid bits clear, registers return to Heun, h = 41/4096
//   and the default interaction matrix.

module three_species_ode_step_top #(
  parameter int FRAC_BITS = tsode_pkg::FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tsode_pkg::pop_t                  pop_first_in,
  input  tsode_pkg::pop_t                  pop_second_in,
  input  tsode_pkg::pop_t                  pop_third_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tsode_pkg::pop_t                  pop_first_out,
  output tsode_pkg::pop_t                  pop_second_out,
  output tsode_pkg::pop_t                  pop_third_out,
  output logic                             saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tsode_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsode_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NS   = tsode_pkg::NSPEC;
  localparam int NST  = 13;
  localparam int LAST = NST - 1;
  localparam int PWD  = tsode_pkg::POP_W;
  localparam int STW  = tsode_pkg::STEP_W;
  localparam int CB   = tsode_pkg::COEF_BITS;
  localparam int SATW = tsode_pkg::SATW;
  localparam int HDW  = STW + 1 + PWD;
  localparam int HPW  = STW + 2 + PWD;

  localparam logic signed [SATW-1:0] RND_E = SATW'(1) <<< (CB - 1);
  localparam logic signed [SATW-1:0] RND_H = SATW'(1) <<< CB;

  // configuration registers
  logic               method;
  logic [STW-1:0]     step_size;
  tsode_pkg::row_t    rows [NS];

  // pipeline control
  logic [NST-1:0]     v;
  logic [NST-1:0]     rdy;

  // pipeline payload
  tsode_pkg::pop_t    x_p   [0:11][NS];
  tsode_pkg::pop_t    d_p   [5:10][NS];
  tsode_pkg::pop_t    e_p   [6:11][NS];
  logic               f_p   [5:11];
  logic signed [HDW-1:0] hd5  [NS];
  logic signed [HPW-1:0] hp11 [NS];
  tsode_pkg::pop_t    pop_o [NS];
  logic               sat_o;

  tsode_pkg::pop_t    d1 [NS];
  logic               c1;
  tsode_pkg::pop_t    d2 [NS];
  logic               c2;
  logic signed [STW:0]   h_s;
  tsode_pkg::sat_t    es [NS];
  logic signed [PWD:0]   ds [NS];
  tsode_pkg::sat_t    rs [NS];

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      method    <= tsode_pkg::RST_METHOD;
      step_size <= tsode_pkg::RST_STEP;
      rows[0]   <= tsode_pkg::RST_ROW0;
      rows[1]   <= tsode_pkg::RST_ROW1;
      rows[2]   <= tsode_pkg::RST_ROW2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tsode_pkg::REG_METHOD: method    <= cfg_data[0];
        tsode_pkg::REG_STEP:   step_size <= cfg_data[STW-1:0];
        tsode_pkg::REG_ROW0:   rows[0]   <= cfg_data;
        tsode_pkg::REG_ROW1:   rows[1]   <= cfg_data;
        tsode_pkg::REG_ROW2:   rows[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage may load when it or any stage after it is empty, or output drains
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = out_ready || !(&v[LAST:k]);
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // population carried alongside the whole datapath
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_p[0][0] <= pop_first_in;
      x_p[0][1] <= pop_second_in;
      x_p[0][2] <= pop_third_in;
    end
    for (int k = 1; k < 12; k++) begin
      if (rdy[k]) begin
        x_p[k] <= x_p[k-1];
      end
    end
  end

  // derivative at the input point, stages 1..4
  tsode_deriv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_deriv_x (
    .clk  (clk),
    .ld   (rdy[4:1]),
    .x    (x_p[0]),
    .rows (rows),
    .d    (d1),
    .clip (c1)
  );

  assign h_s = $signed({1'b0, step_size});

  // stage 5: h * d
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < NS; i++) begin
        hd5[i] <= HDW'(h_s) * HDW'(d1[i]);
      end
      d_p[5] <= d1;
      f_p[5] <= c1;
    end
  end

  // stage 6: Euler update e = x + h*d
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      es[i] = tsode_pkg::sat32(SATW'(x_p[5][i]) + ((SATW'(hd5[i]) + RND_E) >>> CB));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int i = 0; i < NS; i++) begin
        e_p[6][i] <= es[i].val;
      end
      d_p[6] <= d_p[5];
      f_p[6] <= f_p[5] | es[0].clip | es[1].clip | es[2].clip;
    end
  end

  // carry d, e and flag across the second derivative
  for (genvar k = 7; k < 11; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        d_p[k] <= d_p[k-1];
        e_p[k] <= e_p[k-1];
        f_p[k] <= f_p[k-1];
      end
    end
  end

  // derivative at the Euler estimate, stages 7..10
  tsode_deriv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_deriv_e (
    .clk  (clk),
    .ld   (rdy[10:7]),
    .x    (e_p[6]),
    .rows (rows),
    .d    (d2),
    .clip (c2)
  );

  // stage 11: h * (d + d'), kept exact
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      ds[i] = (PWD+1)'(d_p[10][i]) + (PWD+1)'(d2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      for (int i = 0; i < NS; i++) begin
        hp11[i] <= HPW'(h_s) * HPW'(ds[i]);
      end
      e_p[11] <= e_p[10];
      // clamps in the second derivative count only for Heun
      f_p[11] <= f_p[10] | ((method == tsode_pkg::METHOD_HEUN) & c2);
    end
  end

  // stage 12: Heun update or Euler result, output register
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      rs[i] = tsode_pkg::sat32(SATW'(x_p[11][i]) + ((SATW'(hp11[i]) + RND_H) >>> (CB + 1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      if (method == tsode_pkg::METHOD_HEUN) begin
        for (int i = 0; i < NS; i++) begin
          pop_o[i] <= rs[i].val;
        end
        sat_o <= f_p[11] | rs[0].clip | rs[1].clip | rs[2].clip;
      end else begin
        pop_o <= e_p[11];
        sat_o <= f_p[11];
      end
    end
  end

  assign pop_first_out  = pop_o[0];
  assign pop_second_out = pop_o[1];
  assign pop_third_out  = pop_o[2];
  assign saturated      = sat_o;

  // input stalls only with every stage full and the output blocked
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&v) && !out_ready))
    else $error("input stalled while the pipeline has room");

  // a word in the last compute stage moves into an empty output register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v[LAST-1] && !v[LAST]) |=> v[LAST])
    else $error("word lost ahead of the output register");

  // an accepted word occupies the input stage
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted word not captured");

  // nothing is presented right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

### test/testbench.sv
// Self-checking testbench for the three-species Euler/Heun ODE step block.
`timescale 1ns / 1ps

module testbench;

  localparam int     PIPE_DEPTH  = 13;
  localparam int     DRAIN_LIMIT = 20000;
  localparam int     TIMEOUT_NS  = 2000000;
  localparam int     LONG_STALL  = 80;
  localparam longint UNIT        = longint'(1) << tsode_pkg::FRAC_BITS;
  localparam longint POP_HI      = 64'sd2147483647;
  localparam longint POP_LO      = -64'sd2147483648;

  localparam tsode_pkg::pop_t POP_MAX     = 32'sh7FFF_FFFF;
  localparam tsode_pkg::pop_t POP_MIN     = 32'sh8000_0000;
  localparam tsode_pkg::pop_t POP_ONE     = 32'sh0100_0000;
  localparam tsode_pkg::pop_t POP_HALF    = 32'sh0080_0000;
  localparam tsode_pkg::pop_t POP_QUARTER = 32'sh0040_0000;
  localparam tsode_pkg::pop_t POP_3QUART  = 32'sh00C0_0000;
  localparam tsode_pkg::pop_t POP_1HALF   = 32'sh0180_0000;

  localparam logic [tsode_pkg::COEF_W-1:0] LANE_MAX = 16'h7FFF;
  localparam logic [tsode_pkg::COEF_W-1:0] LANE_MIN = 16'h8000;

  // receiver stall patterns
  localparam int RX_ALWAYS   = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_MOSTLY   = 2;
  localparam int RX_PERIODIC = 3;

  typedef struct packed {
    tsode_pkg::pop_t first;
    tsode_pkg::pop_t second;
    tsode_pkg::pop_t third;
    logic sat;
  } step_result_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  tsode_pkg::pop_t pop_first_in, pop_second_in, pop_third_in;
  logic out_valid;
  logic out_ready = 1'b0;
  tsode_pkg::pop_t pop_first_out, pop_second_out, pop_third_out;
  logic saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic [tsode_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tsode_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the registers
  logic                         mdl_method;
  logic [tsode_pkg::STEP_W-1:0] mdl_step;
  tsode_pkg::row_t              mdl_rows [tsode_pkg::NSPEC];
  logic                         clamp_hit;

  step_result_t pending_steps [$];
  int error_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit long_stall_req = 1'b0;
  int long_stall_left = 0;
  int rx_mode = RX_ALWAYS;
  int rx_mode_left = 0;
  int rx_tick = 0;

  three_species_ode_step_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pop_first_in   (pop_first_in),
    .pop_second_in  (pop_second_in),
    .pop_third_in   (pop_third_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pop_first_out  (pop_first_out),
    .pop_second_out (pop_second_out),
    .pop_third_out  (pop_third_out),
    .saturated      (saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // round half up, then floor shift
  function automatic longint round_shift(input longint v, input int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > POP_HI) begin
      clamp_hit = 1'b1;
      return POP_HI;
    end
    if (v < POP_LO) begin
      clamp_hit = 1'b1;
      return POP_LO;
    end
    return v;
  endfunction

  // growth rate of species sp at populations x0..x2
  function automatic longint rate_of(input longint x0, x1, x2, input int sp);
    longint xs [3];
    longint acc;
    logic signed [tsode_pkg::COEF_W-1:0] c;
    int j;
    xs[0] = x0;
    xs[1] = x1;
    xs[2] = x2;
    acc = 0;
    for (j = 0; j < tsode_pkg::NSPEC; j++) begin
      c = mdl_rows[sp][tsode_pkg::COEF_W*j +: tsode_pkg::COEF_W];
      acc += longint'(c) * (UNIT - xs[j]);
    end
    acc = clamp32(round_shift(acc, tsode_pkg::COEF_BITS));
    return clamp32(round_shift(xs[sp] * acc, tsode_pkg::FRAC_BITS));
  endfunction

  function automatic step_result_t next_pops(input tsode_pkg::pop_t p0, p1, p2);
    longint x [3];
    longint d [3];
    longint e [3];
    longint dh [3];
    longint r [3];
    longint h;
    step_result_t res;
    int i;
    clamp_hit = 1'b0;
    x[0] = p0;
    x[1] = p1;
    x[2] = p2;
    h = longint'(mdl_step);
    for (i = 0; i < tsode_pkg::NSPEC; i++) d[i] = rate_of(x[0], x[1], x[2], i);
    for (i = 0; i < tsode_pkg::NSPEC; i++)
      e[i] = clamp32(x[i] + round_shift(h * d[i], tsode_pkg::COEF_BITS));
    if (mdl_method == tsode_pkg::METHOD_HEUN) begin
      for (i = 0; i < tsode_pkg::NSPEC; i++) dh[i] = rate_of(e[0], e[1], e[2], i);
      for (i = 0; i < tsode_pkg::NSPEC; i++)
        r[i] = clamp32(x[i] + round_shift(h * (d[i] + dh[i]), tsode_pkg::COEF_BITS + 1));
    end else begin
      for (i = 0; i < tsode_pkg::NSPEC; i++) r[i] = e[i];
    end
    res.first  = r[0][tsode_pkg::POP_W-1:0];
    res.second = r[1][tsode_pkg::POP_W-1:0];
    res.third  = r[2][tsode_pkg::POP_W-1:0];
    res.sat    = clamp_hit;
    return res;
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    step_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h %h %h %b", $time,
                 pop_first_out, pop_second_out, pop_third_out, saturated);
        error_count++;
      end else begin
        want = pending_steps.pop_front();
        check_field("pop_first_out", want.first, pop_first_out);
        check_field("pop_second_out", want.second, pop_second_out);
        check_field("pop_third_out", want.third, pop_third_out);
        check_field("saturated", {31'd0, want.sat}, {31'd0, saturated});
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stall patterns, plus one long hold-off on request
  always @(posedge clk) begin
    rx_tick++;
    if (long_stall_req) begin
      long_stall_left = LONG_STALL;
      long_stall_req = 1'b0;
    end
    if (long_stall_left > 0) begin
      long_stall_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
        rx_mode_left = $urandom_range(16, 96);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_ALWAYS:   out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY:   out_ready <= ($urandom_range(0, 7) != 0);
        RX_PERIODIC: out_ready <= ((rx_tick % 5) < 3);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------- driver tasks

  // offer one population word; bursts with random gaps in between
  task automatic send_pops(input tsode_pkg::pop_t p0, p1, p2);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    pop_first_in  <= p0;
    pop_second_in <= p1;
    pop_third_in  <= p2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_steps = {pending_steps, next_pops(p0, p1, p2)};
  endtask

  // wait for every outstanding word, then let the pipe settle
  task automatic drain_pipe();
    int waited;
    in_valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (pending_steps.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_steps.size() != 0) begin
      $display("%0t: missing results, expected %0d more, actual 0", $time,
               pending_steps.size());
      error_count++;
      pending_steps.delete();
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // one register write; cfg_valid is left high for the caller to drop
  task automatic write_reg(input logic [tsode_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsode_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tsode_pkg::REG_METHOD: mdl_method  = data[0];
      tsode_pkg::REG_STEP:   mdl_step    = data[tsode_pkg::STEP_W-1:0];
      tsode_pkg::REG_ROW0:   mdl_rows[0] = data;
      tsode_pkg::REG_ROW1:   mdl_rows[1] = data;
      tsode_pkg::REG_ROW2:   mdl_rows[2] = data;
      default: ;
    endcase
  endtask

  // write all registers; unused upper bits carry junk
  task automatic load_config(input logic m, input logic [tsode_pkg::STEP_W-1:0] h,
                             input tsode_pkg::row_t r0, r1, r2);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(tsode_pkg::REG_METHOD, {junk[tsode_pkg::CFG_DATA_W-1:1], m});
    junk = {$urandom, $urandom};
    write_reg(tsode_pkg::REG_STEP,
              {junk[tsode_pkg::CFG_DATA_W-1:tsode_pkg::STEP_W], h});
    write_reg(tsode_pkg::REG_ROW0, r0);
    write_reg(tsode_pkg::REG_ROW1, r1);
    write_reg(tsode_pkg::REG_ROW2, r2);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- random values

  function automatic logic [tsode_pkg::COEF_W-1:0] rand_coef();
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom;
      return v[tsode_pkg::COEF_W-1:0];
    end
    v = $urandom_range(0, 8192);
    v = v - 4096;
    return v[tsode_pkg::COEF_W-1:0];
  endfunction

  function automatic tsode_pkg::row_t rand_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [tsode_pkg::STEP_W-1:0] rand_step();
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom;
      return v[tsode_pkg::STEP_W-1:0];
    end
    v = $urandom_range(1, 1024);
    return v[tsode_pkg::STEP_W-1:0];
  endfunction

  // mostly plausible populations, some full-range words and extremes
  function automatic tsode_pkg::pop_t rand_pop();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h0200_0000);
      5: begin
        v = $urandom_range(0, 32'h0100_0000);
        return -v;
      end
      6, 7: return $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0: return POP_MAX;
          1: return POP_MIN;
          2: return 32'sd0;
          default: return POP_ONE;
        endcase
      end
      default: begin
        v = $urandom_range(0, 512);
        return POP_ONE + v - 256;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // default registers after reset
  task automatic test_reset_defaults();
    send_pops(POP_HALF, POP_HALF, POP_HALF);
    send_pops(POP_ONE, POP_ONE, POP_ONE);
    send_pops(32'sd0, 32'sd0, 32'sd0);
    send_pops(POP_QUARTER, POP_3QUART, POP_1HALF);
    drain_pipe();
  endtask

  // extreme populations and extreme coefficients, saturation expected
  task automatic test_field_extremes();
    send_pops(POP_MAX, POP_MAX, POP_MAX);
    send_pops(POP_MIN, POP_MIN, POP_MIN);
    send_pops(POP_MAX, POP_MIN, 32'sd0);
    send_pops(POP_MIN, POP_MAX, POP_ONE);
    send_pops(-32'sd1, -32'sd1, -32'sd1);
    send_pops(32'sd1, 32'sd1, 32'sd1);
    drain_pipe();
    load_config(tsode_pkg::METHOD_HEUN, 16'hFFFF, {3{LANE_MAX}}, {3{LANE_MIN}},
                {LANE_MIN, 16'h0000, LANE_MAX});
    send_pops(POP_HALF, POP_1HALF, POP_QUARTER);
    send_pops(POP_MAX, POP_MAX, POP_MIN);
    send_pops(POP_MIN, POP_ONE, POP_MAX);
    drain_pipe();
  endtask

  // Euler method, including a zero step
  task automatic test_euler();
    load_config(tsode_pkg::METHOD_EULER, tsode_pkg::RST_STEP, tsode_pkg::RST_ROW0,
                tsode_pkg::RST_ROW1, tsode_pkg::RST_ROW2);
    send_pops(POP_HALF, POP_HALF, POP_HALF);
    send_pops(POP_QUARTER, POP_3QUART, POP_1HALF);
    send_pops(POP_MAX, POP_MIN, POP_ONE);
    drain_pipe();
    load_config(tsode_pkg::METHOD_EULER, 16'd0, tsode_pkg::RST_ROW0,
                tsode_pkg::RST_ROW1, tsode_pkg::RST_ROW2);
    send_pops(POP_1HALF, POP_HALF, POP_3QUART);
    drain_pipe();
  endtask

  // writes to unused indexes must leave the registers alone
  task automatic test_ignored_writes();
    int k;
    logic [63:0] junk;
    load_config(tsode_pkg::METHOD_HEUN, 16'd300, rand_row(), rand_row(), rand_row());
    for (k = int'(tsode_pkg::REG_ROW2) + 1; k < (1 << tsode_pkg::CFG_IDX_W); k++) begin
      junk = {$urandom, $urandom};
      write_reg(k[tsode_pkg::CFG_IDX_W-1:0], junk[tsode_pkg::CFG_DATA_W-1:0]);
    end
    cfg_valid <= 1'b0;
    send_pops(POP_HALF, POP_ONE, POP_1HALF);
    send_pops(POP_QUARTER, POP_QUARTER, POP_3QUART);
    drain_pipe();
  endtask

  // random words under a series of register settings
  task automatic test_random_phases();
    int ph;
    int n;
    logic m;
    logic [tsode_pkg::STEP_W-1:0] h;
    tsode_pkg::row_t r0, r1, r2;
    for (ph = 0; ph < 10; ph++) begin
      m  = (ph == 0) ? tsode_pkg::METHOD_EULER :
           (ph == 1) ? tsode_pkg::METHOD_HEUN : logic'($urandom_range(0, 1));
      h  = (ph == 2) ? 16'd0 : (ph == 3) ? 16'hFFFF : rand_step();
      r0 = rand_row();
      r1 = rand_row();
      r2 = rand_row();
      if (ph == 3) begin
        r0 = {3{LANE_MAX}};
        r1 = {3{LANE_MAX}};
        r2 = {3{LANE_MAX}};
      end else if (ph == 4) begin
        r0 = {3{LANE_MIN}};
        r1 = {3{LANE_MIN}};
        r2 = {3{LANE_MIN}};
      end else if (ph == 5) begin
        r0 = '0;
        r1 = '0;
        r2 = '0;
      end
      load_config(m, h, r0, r1, r2);
      for (n = 0; n < 52; n++) send_pops(rand_pop(), rand_pop(), rand_pop());
      drain_pipe();
    end
  endtask

  // receiver holds off while the sender keeps offering: pipe fills, input stalls
  task automatic test_backpressure();
    int n;
    load_config(tsode_pkg::METHOD_HEUN, rand_step(), tsode_pkg::RST_ROW0,
                tsode_pkg::RST_ROW1, tsode_pkg::RST_ROW2);
    gaps_on = 1'b0;
    long_stall_req = 1'b1;
    for (n = 0; n < 36; n++) send_pops(rand_pop(), rand_pop(), rand_pop());
    gaps_on = 1'b1;
    drain_pipe();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    pop_first_in  = '0;
    pop_second_in = '0;
    pop_third_in  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mdl_method    = tsode_pkg::RST_METHOD;
    mdl_step      = tsode_pkg::RST_STEP;
    mdl_rows[0]   = tsode_pkg::RST_ROW0;
    mdl_rows[1]   = tsode_pkg::RST_ROW1;
    mdl_rows[2]   = tsode_pkg::RST_ROW2;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_euler();
    test_ignored_writes();
    test_random_phases();
    test_backpressure();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tsode_pkg.sv
hdl/tsode_deriv.sv
hdl/three_species_ode_step_top.sv
test/testbench.sv
